### design/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared widths, byte class constants and lead byte classification for the
// utf8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 31;
    localparam int LEN_W   = 3;
    localparam int BITS_W  = 7;
    localparam int CONT_W  = 6;
    localparam int TDATA_I_W = 8;
    localparam int TDATA_O_W = 40;
    localparam int TUSER_O_W = 1;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD5_TAG  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'hFE;
    localparam logic [BYTE_W-1:0] LEAD6_TAG  = 8'hFC;

    localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;
    localparam logic [LEN_W-1:0] LEN_MAX = 3'd6;

    typedef struct packed {
        logic              ok;
        logic [LEN_W-1:0]  len;
        logic [BITS_W-1:0] bits;
    } t_lead;

    function automatic t_lead f_lead(input logic [BYTE_W-1:0] b);
        t_lead l;
        l.ok   = 1'b1;
        l.len  = LEN_ONE;
        l.bits = '0;
        priority if (!b[7]) begin
            l.bits = b[6:0];
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            l.len  = 3'd2;
            l.bits = {2'b00, b[4:0]};
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            l.len  = 3'd3;
            l.bits = {3'b000, b[3:0]};
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            l.len  = 3'd4;
            l.bits = {4'b0000, b[2:0]};
        end else if ((b & LEAD5_MASK) == LEAD5_TAG) begin
            l.len  = 3'd5;
            l.bits = {5'b00000, b[1:0]};
        end else if ((b & LEAD6_MASK) == LEAD6_TAG) begin
            l.len  = LEN_MAX;
            l.bits = {6'b000000, b[0]};
        end else begin
            l.ok = 1'b0;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

### design/utf8_validating_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_validating_stream_decoder_unit
// Byte stream to code point decoder for the extended one-to-six-byte form.
//
// Usage:
//   s_axis carries one raw byte per transfer in tdata[7:0].
//   m_axis carries one result per sequence: tdata holds code_point [30:0]
//   and seq_length [33:31], upper bits zero; tuser[0] is bad_sequence.
//   A lead byte sets the declared length and every following byte of that
//   length is consumed, whatever it holds. Bad sequences return code 0.
//   Throughput is one byte per cycle unless a closing byte waits on a stalled
//   result; the decode state (bytes left, gathered bits, error flag, length)
//   is updated once per byte. The closing byte enters the input register at
//   its transfer; its result then moves into the result register when free.
//   When the receiver stalls, the held result stays on m_axis and one more
//   byte is still taken into the input register; bytes that close no
//   sequence keep flowing while the result waits.
//   Synchronous reset clears both stages and the decode state; after reset
//   the block expects a lead byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validating_stream_decoder_unit
    import u8dec_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [TDATA_I_W-1:0]  s_axis_tdata,   // in_byte [7:0]
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [TDATA_O_W-1:0] m_axis_tdata,   // code_point [30:0], seq_length [33:31]
    output logic [TUSER_O_W-1:0] m_axis_tuser    // bad_sequence [0]
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic [LEN_W-1:0]  r_left, n_left;
    logic [CP_W-1:0]   r_acc, n_acc;
    logic              r_err, n_err;
    logic [LEN_W-1:0]  r_len, n_len;

    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_bad;
    logic [LEN_W-1:0]  r_out_len;

    logic              w_emit;
    logic [CP_W-1:0]   w_cp;
    logic              w_bad;
    logic [LEN_W-1:0]  w_len;
    logic              w_adv;
    logic              w_cont_err;
    logic [CP_W-1:0]   w_shift;
    logic [LEN_W-1:0]  w_left_dec;
    t_lead             w_lead;

    assign w_lead     = f_lead(r_in_byte);
    assign w_cont_err = r_err | ((r_in_byte & CONT_MASK) != CONT_TAG);
    assign w_shift    = {r_acc[CP_W-CONT_W-1:0], r_in_byte[CONT_W-1:0]};
    assign w_left_dec = r_left - LEN_ONE;

    always_comb begin
        w_emit = 1'b0;
        w_cp   = '0;
        w_bad  = 1'b0;
        w_len  = LEN_ONE;
        n_left = r_left;
        n_acc  = r_acc;
        n_err  = r_err;
        n_len  = r_len;
        if (r_left != '0) begin
            if (w_left_dec == '0) begin
                // closing byte of the sequence
                w_emit = 1'b1;
                w_bad  = w_cont_err;
                w_cp   = w_cont_err ? '0 : w_shift;
                w_len  = r_len;
                n_left = '0;
                n_acc  = '0;
                n_err  = 1'b0;
                n_len  = '0;
            end else begin
                n_left = w_left_dec;
                n_acc  = w_shift;
                n_err  = w_cont_err;
            end
        end else if (!w_lead.ok) begin
            w_emit = 1'b1;
            w_bad  = 1'b1;
        end else if (w_lead.len == LEN_ONE) begin
            w_emit = 1'b1;
            w_cp   = {{(CP_W-BITS_W){1'b0}}, w_lead.bits};
        end else begin
            n_left = w_lead.len - LEN_ONE;
            n_acc  = {{(CP_W-BITS_W){1'b0}}, w_lead.bits};
            n_err  = 1'b0;
            n_len  = w_lead.len;
        end
    end

    assign w_adv         = r_in_valid && (!w_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_acc  <= '0;
            r_err  <= 1'b0;
            r_len  <= '0;
        end else if (w_adv) begin
            r_left <= n_left;
            r_acc  <= n_acc;
            r_err  <= n_err;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_cp  <= w_cp;
            r_out_bad <= w_bad;
            r_out_len <= w_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_O_W-CP_W-LEN_W){1'b0}}, r_out_len, r_out_cp};
    assign m_axis_tuser  = r_out_bad;

endmodule

`default_nettype wire

### design/u8dec_checker.sv
// ----------------------------------------------------------------------------
// u8dec_checker
// Port level checks for the utf8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dec_checker
    import u8dec_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 m_axis_tvalid,
    input wire                 m_axis_tready,
    input wire [TDATA_O_W-1:0] m_axis_tdata,
    input wire [TUSER_O_W-1:0] m_axis_tuser
);

    logic [LEN_W-1:0] w_len;
    logic [CP_W-1:0]  w_cp;

    assign w_len = m_axis_tdata[CP_W+LEN_W-1:CP_W];
    assign w_cp  = m_axis_tdata[CP_W-1:0];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> w_cp == '0)
        else $error("bad sequence with non-zero code point");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_len != '0 && w_len <= LEN_MAX &&
            m_axis_tdata[TDATA_O_W-1:CP_W+LEN_W] == '0)
        else $error("sequence length out of range");

    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_len == LEN_ONE && !m_axis_tuser[0] |->
            w_cp[CP_W-1:BITS_W] == '0)
        else $error("single byte result above seven bits");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule

bind utf8_validating_stream_decoder_unit u8dec_checker u_u8dec_checker (.*);

`default_nettype wire
